/* hdl/gws_pkg.sv */
// Shared constants and controller/datapath interface types for the waypoint step block.
// No dependencies; imported by every module under hdl.
package gws_pkg;

    localparam int NODE_COUNT  = 32;
    localparam int MAX_LINKS   = 4;
    localparam int LINK_FIELDS = 4;
    localparam int LINK_LIMIT  = (MAX_LINKS < LINK_FIELDS) ? MAX_LINKS : LINK_FIELDS;

    localparam int IDX_W   = $clog2(NODE_COUNT);
    localparam int CNT_W   = 3;
    localparam int KSEL_W  = $clog2(LINK_FIELDS);
    localparam int COORD_W = 16;
    localparam int POS_W   = 2 * COORD_W;
    localparam int LINKS_W = CNT_W + LINK_FIELDS * IDX_W;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int SQ_W    = PROD_W + 1;
    localparam int DIST_W  = 17;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // latch request fields, clear best
        logic decode;    // write node or read links of current node
        logic k_clr;
        logic k_inc;
        logic pos_rd;    // read neighbour position
        logic diff;      // |target - neighbour|
        logic mul_x;
        logic mul_y;
        logic sq_init;
        logic sq_step;
        logic compare;   // keep neighbour if strictly nearer
        logic publish;   // drive result for one cycle
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_write;
        logic cur_valid;
        logic k_end;
        logic nb_valid;
        logic sq_last;
    } t_dp_sts;

endpackage

/* hdl/gws_datapath.sv */
// Datapath: node store, valid bits, link walk, squares, bit-serial square root and best tracking.
// Depends on gws_pkg; sequenced by gws_ctrl.
module gws_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gws_pkg::t_dp_cmd                   i_dp_cmd,
    output gws_pkg::t_dp_sts                   o_dp_sts,
    input  logic                               i_cmd,
    input  logic [gws_pkg::IDX_W-1:0]          i_node_index,
    input  logic signed [gws_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [gws_pkg::COORD_W-1:0] i_pos_y,
    input  logic [gws_pkg::CNT_W-1:0]          i_link_count,
    input  logic [gws_pkg::IDX_W-1:0]          i_link_0,
    input  logic [gws_pkg::IDX_W-1:0]          i_link_1,
    input  logic [gws_pkg::IDX_W-1:0]          i_link_2,
    input  logic [gws_pkg::IDX_W-1:0]          i_link_3,
    input  logic signed [gws_pkg::COORD_W-1:0] i_target_x,
    input  logic signed [gws_pkg::COORD_W-1:0] i_target_y,
    output logic                               o_valid,
    output logic signed [gws_pkg::COORD_W-1:0] o_near_x,
    output logic signed [gws_pkg::COORD_W-1:0] o_near_y,
    output logic                               o_found,
    output logic [gws_pkg::DIST_W-1:0]         o_distance
);
    import gws_pkg::*;

    // request registers
    logic                          r_cmd;
    logic [IDX_W-1:0]              r_idx;
    logic [COORD_W-1:0]            r_px, r_py;
    logic [CNT_W-1:0]              r_lcnt;
    logic [LINK_FIELDS*IDX_W-1:0]  r_lfld;
    logic signed [COORD_W-1:0]     r_tx, r_ty;

    // node store
    logic [POS_W-1:0]              pos_mem  [NODE_COUNT];
    logic [LINKS_W-1:0]            link_mem [NODE_COUNT];
    logic [NODE_COUNT-1:0]         r_valid;

    logic [LINKS_W-1:0]            r_link_rd;
    logic                          r_cur_valid;
    logic [CNT_W-1:0]              r_k;
    logic [POS_W-1:0]              r_pos_rd;

    logic [COORD_W-1:0]            r_ax, r_ay;
    logic [PROD_W-1:0]             r_prod_x, r_prod_y;
    logic [SQ_W-1:0]               r_rem, r_root, r_bit;

    logic [COORD_W-1:0]            r_best_x, r_best_y;
    logic [DIST_W-1:0]             r_best_d;
    logic                          r_found;

    logic                          r_o_valid;
    logic [COORD_W-1:0]            r_o_x, r_o_y;
    logic                          r_o_found;
    logic [DIST_W-1:0]             r_o_dist;

    logic [CNT_W-1:0]              n_cnt;
    logic [IDX_W-1:0]              nb_idx;
    logic signed [COORD_W:0]       dx, dy;
    logic [COORD_W:0]              adx, ady;
    logic [COORD_W-1:0]            mul_op;
    logic [PROD_W-1:0]             prod;
    logic [SQ_W:0]                 trial;
    logic                          sq_take;
    logic [DIST_W-1:0]             cur_d;
    logic                          nearer;

    // saturate the link count on write
    assign n_cnt = (i_link_count > CNT_W'(LINK_LIMIT)) ? CNT_W'(LINK_LIMIT) : i_link_count;

    assign nb_idx = r_link_rd[CNT_W + r_k[KSEL_W-1:0] * IDX_W +: IDX_W];

    assign dx  = {r_tx[COORD_W-1], r_tx}
               - {r_pos_rd[COORD_W-1], r_pos_rd[COORD_W-1:0]};
    assign dy  = {r_ty[COORD_W-1], r_ty}
               - {r_pos_rd[POS_W-1], r_pos_rd[POS_W-1:COORD_W]};
    assign adx = dx[COORD_W] ? (~dx + 1'b1) : dx;
    assign ady = dy[COORD_W] ? (~dy + 1'b1) : dy;

    // one shared squarer
    assign mul_op = i_dp_cmd.mul_y ? r_ay : r_ax;
    assign prod   = {{COORD_W{1'b0}}, mul_op} * {{COORD_W{1'b0}}, mul_op};

    assign trial   = {1'b0, r_root} + {1'b0, r_bit};
    assign sq_take = {1'b0, r_rem} >= trial;

    assign cur_d  = r_root[DIST_W-1:0];
    assign nearer = !r_found || (cur_d < r_best_d);

    assign o_dp_sts.is_write  = !r_cmd;
    assign o_dp_sts.cur_valid = r_cur_valid;
    assign o_dp_sts.k_end     = r_k >= r_link_rd[CNT_W-1:0];
    assign o_dp_sts.nb_valid  = r_valid[nb_idx];
    assign o_dp_sts.sq_last   = r_bit[0];

    // store: one write port and registered reads
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.decode && !r_cmd) begin
            pos_mem[r_idx]  <= {r_py, r_px};
            link_mem[r_idx] <= {r_lfld, r_lcnt};
        end
        if (i_dp_cmd.decode) begin
            r_link_rd <= link_mem[r_idx];
        end
        if (i_dp_cmd.pos_rd) begin
            r_pos_rd <= pos_mem[nb_idx];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_o_valid <= 1'b0;
            r_found   <= 1'b0;
            r_k       <= '0;
        end else begin
            r_o_valid <= i_dp_cmd.publish;
            if (i_dp_cmd.decode && !r_cmd) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (i_dp_cmd.load) begin
                r_found <= 1'b0;
            end else if (i_dp_cmd.compare && nearer) begin
                r_found <= 1'b1;
            end
            if (i_dp_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_dp_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd    <= i_cmd;
            r_idx    <= i_node_index;
            r_px     <= i_pos_x;
            r_py     <= i_pos_y;
            r_lcnt   <= n_cnt;
            r_lfld   <= {i_link_3, i_link_2, i_link_1, i_link_0};
            r_tx     <= i_target_x;
            r_ty     <= i_target_y;
            r_best_x <= '0;
            r_best_y <= '0;
            r_best_d <= '0;
        end else if (i_dp_cmd.compare && nearer) begin
            r_best_x <= r_pos_rd[COORD_W-1:0];
            r_best_y <= r_pos_rd[POS_W-1:COORD_W];
            r_best_d <= cur_d;
        end
        if (i_dp_cmd.decode) begin
            r_cur_valid <= r_valid[r_idx];
        end
        if (i_dp_cmd.diff) begin
            r_ax <= adx[COORD_W-1:0];
            r_ay <= ady[COORD_W-1:0];
        end
        if (i_dp_cmd.mul_x) begin
            r_prod_x <= prod;
        end
        if (i_dp_cmd.mul_y) begin
            r_prod_y <= prod;
        end
        if (i_dp_cmd.sq_init) begin
            r_rem  <= {1'b0, r_prod_x} + {1'b0, r_prod_y};
            r_root <= '0;
            r_bit  <= {1'b1, {(SQ_W-1){1'b0}}};
        end else if (i_dp_cmd.sq_step) begin
            if (sq_take) begin
                r_rem  <= r_rem - trial[SQ_W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_dp_cmd.publish) begin
            r_o_x     <= r_best_x;
            r_o_y     <= r_best_y;
            r_o_found <= r_found;
            r_o_dist  <= r_best_d;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_near_x   = r_o_x;
    assign o_near_y   = r_o_y;
    assign o_found    = r_o_found;
    assign o_distance = r_o_dist;

endmodule

/* hdl/gws_ctrl.sv */
// Controller: sequences decode, link walk, squaring, root extraction and result publish.
// Depends on gws_pkg; drives gws_datapath.
module gws_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output gws_pkg::t_dp_cmd o_dp_cmd,
    input  gws_pkg::t_dp_sts i_dp_sts
);
    import gws_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_NSEL,
        S_DIFF,
        S_MULX,
        S_MULY,
        S_SQINIT,
        S_SQRT,
        S_CMP,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_dp_cmd.load = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_dp_cmd.decode = 1'b1;
                o_dp_cmd.k_clr  = 1'b1;
                n_state         = i_dp_sts.is_write ? S_DONE : S_NSEL;
            end
            S_NSEL: begin
                if (!i_dp_sts.cur_valid || i_dp_sts.k_end) begin
                    n_state = S_DONE;
                end else if (!i_dp_sts.nb_valid) begin
                    o_dp_cmd.k_inc = 1'b1;
                end else begin
                    o_dp_cmd.pos_rd = 1'b1;
                    n_state         = S_DIFF;
                end
            end
            S_DIFF: begin
                o_dp_cmd.diff = 1'b1;
                n_state       = S_MULX;
            end
            S_MULX: begin
                o_dp_cmd.mul_x = 1'b1;
                n_state        = S_MULY;
            end
            S_MULY: begin
                o_dp_cmd.mul_y = 1'b1;
                n_state        = S_SQINIT;
            end
            S_SQINIT: begin
                o_dp_cmd.sq_init = 1'b1;
                n_state          = S_SQRT;
            end
            S_SQRT: begin
                o_dp_cmd.sq_step = 1'b1;
                if (i_dp_sts.sq_last) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_dp_cmd.compare = 1'b1;
                o_dp_cmd.k_inc   = 1'b1;
                n_state          = S_NSEL;
            end
            S_DONE: begin
                o_dp_cmd.publish = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

/* hdl/greedy_waypoint_step.sv */
// Top level of the greedy waypoint step block: ports, controller and datapath.
// Depends on gws_pkg, gws_ctrl and gws_datapath.
//
// Use: a request is taken when start is high and busy is low. cmd = 0 writes one
// node (position, saturated link count, four link indices) and marks it valid;
// cmd = 1 names the current node and a target point and asks for the neighbour
// nearest the target, by floored Euclidean distance, first link winning ties.
// Every request gives exactly one result: o_valid is high for one cycle with
// o_near_x, o_near_y, o_found and o_distance. A write, an invalid current node or
// a node with no valid link gives zeros with o_found low.
// A write passes decode and then publishes its result. A query decodes, then walks
// the links in order, skipping invalid ones; for each valid link the 17-step
// bit-serial square root dominates the work.
// busy is high from the cycle after acceptance until the result is driven, so a
// new request may be taken in the very cycle its predecessor's result is shown.
// There is one request in flight at a time.
// Reset (synchronous, active low) clears all node valid bits and the controller;
// the node store is not cleared, as the contents of invalid nodes are never used.
// The receiver cannot stall: results must be taken in their strobe cycle.
module greedy_waypoint_step (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cmd,
    input  logic [gws_pkg::IDX_W-1:0]          i_node_index,
    input  logic signed [gws_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [gws_pkg::COORD_W-1:0] i_pos_y,
    input  logic [gws_pkg::CNT_W-1:0]          i_link_count,
    input  logic [gws_pkg::IDX_W-1:0]          i_link_0,
    input  logic [gws_pkg::IDX_W-1:0]          i_link_1,
    input  logic [gws_pkg::IDX_W-1:0]          i_link_2,
    input  logic [gws_pkg::IDX_W-1:0]          i_link_3,
    input  logic signed [gws_pkg::COORD_W-1:0] i_target_x,
    input  logic signed [gws_pkg::COORD_W-1:0] i_target_y,
    output logic                               o_valid,
    output logic signed [gws_pkg::COORD_W-1:0] o_near_x,
    output logic signed [gws_pkg::COORD_W-1:0] o_near_y,
    output logic                               o_found,
    output logic [gws_pkg::DIST_W-1:0]         o_distance
);
    import gws_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: owns busy and every datapath strobe
    gws_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_dp_cmd (dp_cmd),
        .i_dp_sts (dp_sts)
    );

    // node store, arithmetic and result registers
    gws_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp_cmd     (dp_cmd),
        .o_dp_sts     (dp_sts),
        .i_cmd        (i_cmd),
        .i_node_index (i_node_index),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_link_count (i_link_count),
        .i_link_0     (i_link_0),
        .i_link_1     (i_link_1),
        .i_link_2     (i_link_2),
        .i_link_3     (i_link_3),
        .i_target_x   (i_target_x),
        .i_target_y   (i_target_y),
        .o_valid      (o_valid),
        .o_near_x     (o_near_x),
        .o_near_y     (o_near_y),
        .o_found      (o_found),
        .o_distance   (o_distance)
    );

    // a result with nothing found carries zeros
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_near_x == '0 && o_near_y == '0 && o_distance == '0)
        else $error("empty result carries non-zero payload");

    // a result strobe only ends a busy period
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy))
        else $error("result without a request in flight");

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // no strobe while busy: result is published as busy falls
    a_no_valid_midway: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $fell(busy) || !$past(busy, 2) || !busy)
        else $error("result strobe in the middle of a request");

endmodule
